// ----- sv/cdpwm_pkg.sv -----
package cdpwm_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_MOTOR_PERIOD = 2'd0;
  localparam logic [1:0] REG_SERVO_PERIOD = 2'd1;
  localparam logic [1:0] REG_SERVO_CENTER = 2'd2;
  localparam logic [1:0] REG_INITIAL_DUTY = 2'd3;

  localparam int unsigned CFG_WIDTH = 12;

  localparam logic [CFG_WIDTH-1:0] RST_MOTOR_PERIOD = 12'd200;
  localparam logic [CFG_WIDTH-1:0] RST_SERVO_PERIOD = 12'd2000;
  localparam logic [CFG_WIDTH-1:0] RST_SERVO_CENTER = 12'd150;
  localparam logic [CFG_WIDTH-1:0] RST_INITIAL_DUTY = 12'd80;

  // Operation codes of the input channel
  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_COMMAND = 1'b1;

  // Command characters
  localparam logic [7:0] CMD_DUTY_UP_FINE   = 8'h2B; // '+'
  localparam logic [7:0] CMD_DUTY_UP_COARSE = 8'h5A; // 'Z'
  localparam logic [7:0] CMD_DUTY_DN_FINE   = 8'h2D; // '-'
  localparam logic [7:0] CMD_DUTY_DN_COARSE = 8'h58; // 'X'
  localparam logic [7:0] CMD_FORWARD        = 8'h57; // 'W'
  localparam logic [7:0] CMD_REVERSE        = 8'h53; // 'S'
  localparam logic [7:0] CMD_STOP           = 8'h50; // 'P'
  localparam logic [7:0] CMD_STEER_UP       = 8'h41; // 'A'
  localparam logic [7:0] CMD_STEER_DN       = 8'h44; // 'D'
  localparam logic [7:0] CMD_STEER_CENTRE   = 8'h4F; // 'O'
  localparam logic [7:0] CMD_REINIT         = 8'h46; // 'F'
  localparam logic [7:0] CMD_FOLLOW         = 8'h42; // 'B'
  localparam logic [7:0] CMD_HIGH_BEAM      = 8'h48; // 'H'
  localparam logic [7:0] CMD_LOW_BEAM       = 8'h4C; // 'L'
  localparam logic [7:0] CMD_HORN           = 8'h51; // 'Q'
  localparam logic [7:0] CMD_PERIPHERAL     = 8'h63; // 'c'
  localparam logic [7:0] CMD_DIGIT_FIRST    = 8'h30; // '0'
  localparam logic [7:0] CMD_DIGIT_LAST     = 8'h37; // '7'

  localparam int unsigned DUTY_STEP_FINE   = 1;
  localparam int unsigned DUTY_STEP_COARSE = 10;

  // Drive modes
  localparam logic [1:0] MODE_INIT = 2'd0;
  localparam logic [1:0] MODE_STOP = 2'd1;
  localparam logic [1:0] MODE_FWD  = 2'd2;
  localparam logic [1:0] MODE_REV  = 2'd3;

  // Status codes
  localparam logic [1:0] STATUS_DONE    = 2'd0;
  localparam logic [1:0] STATUS_UNKNOWN = 2'd1;
  localparam logic [1:0] STATUS_TICK    = 2'd2;

  // Lamp bits
  localparam logic [3:0] LAMP_BRAKE   = 4'b0001;
  localparam logic [3:0] LAMP_REVERSE = 4'b0010;
  localparam logic [3:0] LAMP_LEFT    = 4'b0100;
  localparam logic [3:0] LAMP_RIGHT   = 4'b1000;

  // H-bridge pairs: out1/out3 drive forward, out2/out4 drive reverse
  localparam logic [3:0] BRIDGE_FWD_PAIR = 4'b0101;
  localparam logic [3:0] BRIDGE_REV_PAIR = 4'b1010;
  localparam logic [3:0] BRIDGE_ALL      = 4'b1111;

  // Accessory bits
  localparam logic [3:0] ACC_HIGH_BEAM  = 4'b0001;
  localparam logic [3:0] ACC_LOW_BEAM   = 4'b0010;
  localparam logic [3:0] ACC_HORN       = 4'b0100;
  localparam logic [3:0] ACC_PERIPHERAL = 4'b1000;

  typedef struct packed {
    logic [CFG_WIDTH-1:0] motor_period;
    logic [CFG_WIDTH-1:0] servo_period;
    logic [CFG_WIDTH-1:0] servo_center;
    logic [CFG_WIDTH-1:0] initial_duty;
  } cfg_regs_t;

  // Output latches and drive mode
  typedef struct packed {
    logic       servo_pin;
    logic [3:0] bridge;
    logic [3:0] lamp;
    logic [3:0] accessory;
    logic [7:0] custom;
    logic [1:0] mode;
  } latch_t;

  localparam latch_t LATCH_RESET = '{
    servo_pin: 1'b0,
    bridge:    BRIDGE_ALL,
    lamp:      LAMP_BRAKE,
    accessory: 4'b0000,
    custom:    8'h00,
    mode:      MODE_INIT
  };

endpackage

// ----- sv/cdpwm_step.sv -----
// Next-state logic for one tick or one command byte.
module cdpwm_step #(
  parameter int unsigned COUNT_WIDTH = 12
) (
  input  cdpwm_pkg::cfg_regs_t   cfg,
  input  logic                   operation,
  input  logic [7:0]             command,
  input  logic [COUNT_WIDTH-1:0] duty_i,
  input  logic [COUNT_WIDTH-1:0] steer_i,
  input  logic [COUNT_WIDTH-1:0] servo_timer_i,
  input  logic [COUNT_WIDTH-1:0] motor_timer_i,
  input  cdpwm_pkg::latch_t      latch_i,
  output logic [COUNT_WIDTH-1:0] duty_o,
  output logic [COUNT_WIDTH-1:0] steer_o,
  output logic [COUNT_WIDTH-1:0] servo_timer_o,
  output logic [COUNT_WIDTH-1:0] motor_timer_o,
  output cdpwm_pkg::latch_t      latch_o,
  output logic [1:0]             status,
  output logic                   follow_request
);

  // Compare width covers both the counters and the 12-bit registers.
  localparam int unsigned CMP_W =
    ((COUNT_WIDTH > cdpwm_pkg::CFG_WIDTH) ? COUNT_WIDTH : cdpwm_pkg::CFG_WIDTH) + 1;

  logic [CMP_W-1:0]       motor_period_x;
  logic [CMP_W-1:0]       servo_period_x;
  logic [CMP_W-1:0]       center_x;
  logic [CMP_W-1:0]       init_duty_x;
  logic [CMP_W-1:0]       duty_x;
  logic [CMP_W-1:0]       steer_x;
  logic [CMP_W-1:0]       steer_new_x;
  logic [COUNT_WIDTH-1:0] center_cw;
  logic [COUNT_WIDTH-1:0] init_duty_cw;
  logic [COUNT_WIDTH-1:0] steer_new;
  logic [COUNT_WIDTH:0]   duty_up_fine;
  logic [COUNT_WIDTH:0]   duty_up_coarse;
  logic [CMP_W-1:0]       duty_dn_fine_x;
  logic [CMP_W-1:0]       duty_dn_coarse_x;
  logic [COUNT_WIDTH:0]   step_fine;
  logic [COUNT_WIDTH:0]   step_coarse;
  logic [COUNT_WIDTH-1:0] servo_t1;
  logic [COUNT_WIDTH-1:0] motor_t1;
  logic [3:0]             turn_lamps;
  logic                   steer_cmd;

  assign motor_period_x = CMP_W'(cfg.motor_period);
  assign servo_period_x = CMP_W'(cfg.servo_period);
  assign center_x       = CMP_W'(cfg.servo_center);
  assign init_duty_x    = CMP_W'(cfg.initial_duty);
  assign center_cw      = center_x[COUNT_WIDTH-1:0];
  assign init_duty_cw   = init_duty_x[COUNT_WIDTH-1:0];
  assign duty_x         = CMP_W'(duty_i);
  assign steer_x        = CMP_W'(steer_i);

  assign step_fine      = (COUNT_WIDTH+1)'(cdpwm_pkg::DUTY_STEP_FINE);
  assign step_coarse    = (COUNT_WIDTH+1)'(cdpwm_pkg::DUTY_STEP_COARSE);
  assign duty_up_fine   = {1'b0, duty_i} + step_fine;
  assign duty_up_coarse = {1'b0, duty_i} + step_coarse;
  assign duty_dn_fine_x   = duty_x - CMP_W'(cdpwm_pkg::DUTY_STEP_FINE);
  assign duty_dn_coarse_x = duty_x - CMP_W'(cdpwm_pkg::DUTY_STEP_COARSE);

  assign servo_t1 = servo_timer_i + COUNT_WIDTH'(1);
  assign motor_t1 = motor_timer_i + COUNT_WIDTH'(1);

  // Steering value after a steering command, used for the cornering lamps.
  always_comb begin
    steer_new = steer_i;
    steer_cmd = 1'b0;
    case (command)
      cdpwm_pkg::CMD_STEER_UP: begin
        steer_cmd = 1'b1;
        if ((steer_x < servo_period_x) && (steer_i != {COUNT_WIDTH{1'b1}})) begin
          steer_new = steer_i + COUNT_WIDTH'(1);
        end
      end
      cdpwm_pkg::CMD_STEER_DN: begin
        steer_cmd = 1'b1;
        if (steer_i != '0) begin
          steer_new = steer_i - COUNT_WIDTH'(1);
        end
      end
      cdpwm_pkg::CMD_STEER_CENTRE: begin
        steer_cmd = 1'b1;
        steer_new = center_cw;
      end
      default: begin
        steer_new = steer_i;
      end
    endcase
  end

  assign steer_new_x = CMP_W'(steer_new);
  assign turn_lamps  = (steer_new_x < center_x) ? cdpwm_pkg::LAMP_RIGHT :
                       (steer_new_x > center_x) ? cdpwm_pkg::LAMP_LEFT  : 4'b0000;

  always_comb begin
    duty_o         = duty_i;
    steer_o        = steer_i;
    servo_timer_o  = servo_timer_i;
    motor_timer_o  = motor_timer_i;
    latch_o        = latch_i;
    status         = cdpwm_pkg::STATUS_DONE;
    follow_request = 1'b0;

    if (operation == cdpwm_pkg::OP_TICK) begin
      status            = cdpwm_pkg::STATUS_TICK;
      latch_o.servo_pin = (servo_t1 > steer_i);
      servo_timer_o     = (CMP_W'(servo_t1) >= servo_period_x) ? '0 : servo_t1;
      if (motor_t1 <= duty_i) begin
        if (latch_i.mode == cdpwm_pkg::MODE_FWD) begin
          latch_o.bridge = latch_i.bridge | cdpwm_pkg::BRIDGE_FWD_PAIR;
        end else if (latch_i.mode == cdpwm_pkg::MODE_REV) begin
          latch_o.bridge = latch_i.bridge | cdpwm_pkg::BRIDGE_REV_PAIR;
        end
      end else begin
        if (latch_i.mode == cdpwm_pkg::MODE_FWD) begin
          latch_o.bridge = latch_i.bridge & ~cdpwm_pkg::BRIDGE_FWD_PAIR;
        end else if (latch_i.mode == cdpwm_pkg::MODE_REV) begin
          latch_o.bridge = latch_i.bridge & ~cdpwm_pkg::BRIDGE_REV_PAIR;
        end
      end
      motor_timer_o = (CMP_W'(motor_t1) >= motor_period_x) ? '0 : motor_t1;
    end else begin
      if (steer_cmd) begin
        steer_o      = steer_new;
        latch_o.lamp = (latch_i.lamp & ~(cdpwm_pkg::LAMP_LEFT | cdpwm_pkg::LAMP_RIGHT))
                       | turn_lamps;
      end
      case (command) inside
        cdpwm_pkg::CMD_DUTY_UP_FINE: begin
          if (!duty_up_fine[COUNT_WIDTH] && (CMP_W'(duty_up_fine) <= motor_period_x)) begin
            duty_o = duty_up_fine[COUNT_WIDTH-1:0];
          end
        end
        cdpwm_pkg::CMD_DUTY_UP_COARSE: begin
          if (!duty_up_coarse[COUNT_WIDTH] &&
              (CMP_W'(duty_up_coarse) <= motor_period_x)) begin
            duty_o = duty_up_coarse[COUNT_WIDTH-1:0];
          end
        end
        cdpwm_pkg::CMD_DUTY_DN_FINE: begin
          if ((duty_x >= CMP_W'(cdpwm_pkg::DUTY_STEP_FINE)) &&
              (duty_dn_fine_x <= motor_period_x)) begin
            duty_o = duty_dn_fine_x[COUNT_WIDTH-1:0];
          end
        end
        cdpwm_pkg::CMD_DUTY_DN_COARSE: begin
          if ((duty_x >= CMP_W'(cdpwm_pkg::DUTY_STEP_COARSE)) &&
              (duty_dn_coarse_x <= motor_period_x)) begin
            duty_o = duty_dn_coarse_x[COUNT_WIDTH-1:0];
          end
        end
        cdpwm_pkg::CMD_FORWARD: begin
          // Leaving reverse passes through stop, which raises every line first.
          latch_o.bridge = ((latch_i.mode == cdpwm_pkg::MODE_REV) ?
                            cdpwm_pkg::BRIDGE_ALL : latch_i.bridge)
                           & ~cdpwm_pkg::BRIDGE_REV_PAIR;
          latch_o.lamp   = latch_i.lamp & ~(cdpwm_pkg::LAMP_BRAKE | cdpwm_pkg::LAMP_REVERSE);
          latch_o.mode   = cdpwm_pkg::MODE_FWD;
        end
        cdpwm_pkg::CMD_REVERSE: begin
          latch_o.bridge = ((latch_i.mode == cdpwm_pkg::MODE_FWD) ?
                            cdpwm_pkg::BRIDGE_ALL : latch_i.bridge)
                           & ~cdpwm_pkg::BRIDGE_FWD_PAIR;
          latch_o.lamp   = (latch_i.lamp & ~cdpwm_pkg::LAMP_BRAKE) | cdpwm_pkg::LAMP_REVERSE;
          latch_o.mode   = cdpwm_pkg::MODE_REV;
        end
        cdpwm_pkg::CMD_STOP: begin
          latch_o.bridge = cdpwm_pkg::BRIDGE_ALL;
          latch_o.lamp   = (latch_i.lamp & ~cdpwm_pkg::LAMP_REVERSE) | cdpwm_pkg::LAMP_BRAKE;
          latch_o.mode   = cdpwm_pkg::MODE_STOP;
        end
        cdpwm_pkg::CMD_STEER_UP, cdpwm_pkg::CMD_STEER_DN, cdpwm_pkg::CMD_STEER_CENTRE: begin
          status = cdpwm_pkg::STATUS_DONE;
        end
        cdpwm_pkg::CMD_REINIT: begin
          duty_o        = init_duty_cw;
          steer_o       = center_cw;
          servo_timer_o = '0;
          motor_timer_o = '0;
          latch_o       = cdpwm_pkg::LATCH_RESET;
        end
        cdpwm_pkg::CMD_FOLLOW: begin
          follow_request = 1'b1;
        end
        cdpwm_pkg::CMD_HIGH_BEAM: begin
          latch_o.accessory = latch_i.accessory ^ cdpwm_pkg::ACC_HIGH_BEAM;
        end
        cdpwm_pkg::CMD_LOW_BEAM: begin
          latch_o.accessory = latch_i.accessory ^ cdpwm_pkg::ACC_LOW_BEAM;
        end
        cdpwm_pkg::CMD_HORN: begin
          latch_o.accessory = latch_i.accessory ^ cdpwm_pkg::ACC_HORN;
        end
        cdpwm_pkg::CMD_PERIPHERAL: begin
          latch_o.accessory = latch_i.accessory ^ cdpwm_pkg::ACC_PERIPHERAL;
        end
        [cdpwm_pkg::CMD_DIGIT_FIRST:cdpwm_pkg::CMD_DIGIT_LAST]: begin
          latch_o.custom = latch_i.custom ^ (8'b1 << command[2:0]);
        end
        default: begin
          status = cdpwm_pkg::STATUS_UNKNOWN;
        end
      endcase
    end
  end

endmodule

// ----- sv/car_drive_command_pwm_controller_top.sv -----
// An input transfer reaches its result through the input register and then the result register.
// Throughput: one item per cycle while the result side keeps taking transfers.
// The next-state logic between the two registers sets that figure: it is a single pass.
// Reset (rst_n low, synchronous) restores the default configuration registers, clears
// the drive state to its power-up values and empties both pipeline registers.
module car_drive_command_pwm_controller_top #(
  parameter int unsigned COUNT_WIDTH = 12
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [7:0]  in_command,

  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_servo_pwm,
  output logic [3:0]  out_bridge_lines,
  output logic [3:0]  out_lamp_bits,
  output logic [3:0]  out_accessory_bits,
  output logic [7:0]  out_custom_bits,
  output logic [1:0]  out_drive_mode,
  output logic [11:0] out_duty_now,
  output logic [11:0] out_steer_now,
  output logic [1:0]  out_status,
  output logic        out_follow_request
);

  // Width used to move counter-width values onto the fixed 12-bit result fields.
  localparam int unsigned EXT_W =
    (COUNT_WIDTH > cdpwm_pkg::CFG_WIDTH) ? COUNT_WIDTH : cdpwm_pkg::CFG_WIDTH;

  // Configuration registers. They are to be written only while the block is idle (a rule for the user
  // that the block itself does not enforce), so the next-state logic may read them directly.
  cdpwm_pkg::cfg_regs_t cfg_r;

  // Input register: holds one accepted item until the result register has room.
  logic       in_hold_valid_r;
  logic       in_hold_op_r;
  logic [7:0] in_hold_cmd_r;

  // Drive state.
  logic [COUNT_WIDTH-1:0] duty_r,        duty_nxt;
  logic [COUNT_WIDTH-1:0] steer_r,       steer_nxt;
  logic [COUNT_WIDTH-1:0] servo_timer_r, servo_timer_nxt;
  logic [COUNT_WIDTH-1:0] motor_timer_r, motor_timer_nxt;
  cdpwm_pkg::latch_t      latch_r,       latch_nxt;
  logic [1:0]             status_nxt;
  logic                   follow_nxt;

  // Result register.
  logic              out_valid_r;
  cdpwm_pkg::latch_t out_latch_r;
  logic [11:0]       out_duty_r;
  logic [11:0]       out_steer_r;
  logic [1:0]        out_status_r;
  logic              out_follow_r;

  logic [EXT_W-1:0]  duty_ext;
  logic [EXT_W-1:0]  steer_ext;
  logic [EXT_W-1:0]  init_duty_ext;
  logic [EXT_W-1:0]  center_ext;

  logic result_free;
  logic advance;

  // The result register is free when empty or when its transfer completes this cycle.
  assign result_free = !out_valid_r || out_ready;
  assign advance     = in_hold_valid_r && result_free;
  assign in_ready    = !in_hold_valid_r || result_free;

  assign init_duty_ext = EXT_W'(cdpwm_pkg::RST_INITIAL_DUTY);
  assign center_ext    = EXT_W'(cdpwm_pkg::RST_SERVO_CENTER);

  cdpwm_step #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_step (
    .cfg            (cfg_r),
    .operation      (in_hold_op_r),
    .command        (in_hold_cmd_r),
    .duty_i         (duty_r),
    .steer_i        (steer_r),
    .servo_timer_i  (servo_timer_r),
    .motor_timer_i  (motor_timer_r),
    .latch_i        (latch_r),
    .duty_o         (duty_nxt),
    .steer_o        (steer_nxt),
    .servo_timer_o  (servo_timer_nxt),
    .motor_timer_o  (motor_timer_nxt),
    .latch_o        (latch_nxt),
    .status         (status_nxt),
    .follow_request (follow_nxt)
  );

  assign duty_ext  = EXT_W'(duty_nxt);
  assign steer_ext = EXT_W'(steer_nxt);

  // Configuration port: one register per write, no read-back.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.motor_period <= cdpwm_pkg::RST_MOTOR_PERIOD;
      cfg_r.servo_period <= cdpwm_pkg::RST_SERVO_PERIOD;
      cfg_r.servo_center <= cdpwm_pkg::RST_SERVO_CENTER;
      cfg_r.initial_duty <= cdpwm_pkg::RST_INITIAL_DUTY;
    end else if (cfg_we) begin
      case (cfg_index)
        cdpwm_pkg::REG_MOTOR_PERIOD: cfg_r.motor_period <= cfg_data;
        cdpwm_pkg::REG_SERVO_PERIOD: cfg_r.servo_period <= cfg_data;
        cdpwm_pkg::REG_SERVO_CENTER: cfg_r.servo_center <= cfg_data;
        cdpwm_pkg::REG_INITIAL_DUTY: cfg_r.initial_duty <= cfg_data;
        default: cfg_r <= cfg_r;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_hold_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_hold_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_hold_op_r  <= in_operation;
      in_hold_cmd_r <= in_command;
    end
  end

  // Drive state advances once per item, as the item moves into the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_r        <= init_duty_ext[COUNT_WIDTH-1:0];
      steer_r       <= center_ext[COUNT_WIDTH-1:0];
      servo_timer_r <= '0;
      motor_timer_r <= '0;
      latch_r       <= cdpwm_pkg::LATCH_RESET;
    end else if (advance) begin
      duty_r        <= duty_nxt;
      steer_r       <= steer_nxt;
      servo_timer_r <= servo_timer_nxt;
      motor_timer_r <= motor_timer_nxt;
      latch_r       <= latch_nxt;
    end
  end

  // Result register: valid flag under reset, payload only loaded.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_latch_r  <= latch_nxt;
      out_duty_r   <= duty_ext[11:0];
      out_steer_r  <= steer_ext[11:0];
      out_status_r <= status_nxt;
      out_follow_r <= follow_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_servo_pwm      = out_latch_r.servo_pin;
  assign out_bridge_lines   = out_latch_r.bridge;
  assign out_lamp_bits      = out_latch_r.lamp;
  assign out_accessory_bits = out_latch_r.accessory;
  assign out_custom_bits    = out_latch_r.custom;
  assign out_drive_mode     = out_latch_r.mode;
  assign out_duty_now       = out_duty_r;
  assign out_steer_now      = out_steer_r;
  assign out_status         = out_status_r;
  assign out_follow_request = out_follow_r;

endmodule

// ----- sv/cdpwm_checker.sv -----
module cdpwm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  out_bridge_lines,
  input logic [3:0]  out_lamp_bits,
  input logic [1:0]  out_drive_mode,
  input logic [11:0] out_duty_now,
  input logic [1:0]  out_status,
  input logic        out_follow_request
);

  // A stalled result keeps its payload.
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_bridge_lines) &&
      $stable(out_duty_now) && $stable(out_status))
    else $error("result changed while stalled");

  // Only the follow command raises the follow request, and it always completes.
  a_follow_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_follow_request |-> out_status == cdpwm_pkg::STATUS_DONE)
    else $error("follow request with wrong status");

  // Forward never drives the reverse pair and reverse never the forward pair.
  a_bridge_pairs: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      ((out_drive_mode != cdpwm_pkg::MODE_FWD) ||
       ((out_bridge_lines & cdpwm_pkg::BRIDGE_REV_PAIR) == 4'b0000)) &&
      ((out_drive_mode != cdpwm_pkg::MODE_REV) ||
       ((out_bridge_lines & cdpwm_pkg::BRIDGE_FWD_PAIR) == 4'b0000)))
    else $error("H-bridge shoot-through pattern");

  // Stopped or initialised: all bridge lines high and the brake lamp on.
  a_stopped_braked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_drive_mode == cdpwm_pkg::MODE_STOP) ||
                  (out_drive_mode == cdpwm_pkg::MODE_INIT)) |->
      (out_bridge_lines == cdpwm_pkg::BRIDGE_ALL) && out_lamp_bits[0])
    else $error("stopped car not braked");

endmodule

bind car_drive_command_pwm_controller_top cdpwm_checker u_cdpwm_checker (.*);

// ----- tb/sv/car_drive_command_pwm_controller_top_tb.sv -----
package car_drive_tb_pkg;
  timeunit 1ns;
  timeprecision 1ps;

  import cdpwm_pkg::*;

  // One result of the block, in the order of its result ports.
  typedef struct packed {
    logic        servo_pwm;
    logic [3:0]  bridge_lines;
    logic [3:0]  lamp_bits;
    logic [3:0]  accessory_bits;
    logic [7:0]  custom_bits;
    logic [1:0]  drive_mode;
    logic [11:0] duty_now;
    logic [11:0] steer_now;
    logic [1:0]  status;
    logic        follow_request;
  } drive_outputs_t;

  class drive_output_checker;
    logic [11:0] motor_period, servo_period, servo_center, initial_duty;
    logic [1:0]  mode;
    logic [11:0] duty, steer, servo_timer, motor_timer;
    logic [3:0]  bridge, lamp, accessory;
    logic [7:0]  custom;
    logic        servo_pin;
    drive_outputs_t predicted_outputs[$];
    int mismatches, ticks_seen, commands_seen, unknown_seen, results_seen;

    function new();
      motor_period = RST_MOTOR_PERIOD;
      servo_period = RST_SERVO_PERIOD;
      servo_center = RST_SERVO_CENTER;
      initial_duty = RST_INITIAL_DUTY;
      clear_car();
    endfunction

    function void clear_car();
      mode        = MODE_INIT;
      duty        = initial_duty;
      steer       = servo_center;
      servo_timer = '0;
      motor_timer = '0;
      bridge      = BRIDGE_ALL;
      lamp        = LAMP_BRAKE;
      accessory   = '0;
      custom      = '0;
      servo_pin   = 1'b0;
    endfunction

    function void write_reg(logic [1:0] index, logic [11:0] value);
      case (index)
        REG_MOTOR_PERIOD: motor_period = value;
        REG_SERVO_PERIOD: servo_period = value;
        REG_SERVO_CENTER: servo_center = value;
        REG_INITIAL_DUTY: initial_duty = value;
        default: ;
      endcase
    endfunction

    function void apply_stop();
      lamp   = (lamp & ~LAMP_REVERSE) | LAMP_BRAKE;
      bridge = BRIDGE_ALL;
      mode   = MODE_STOP;
    endfunction

    function void update_turn_lamps();
      lamp &= ~(LAMP_LEFT | LAMP_RIGHT);
      if (steer < servo_center) lamp |= LAMP_RIGHT;
      else if (steer > servo_center) lamp |= LAMP_LEFT;
    endfunction

    function void raise_duty(int unsigned step);
      int unsigned sum;
      sum = duty + step;
      if (sum <= motor_period && sum <= 32'hFFF) duty = sum[11:0];
    endfunction

    function void lower_duty(int unsigned step);
      int unsigned diff;
      diff = duty - step;
      if (duty >= step && diff <= motor_period) duty = diff[11:0];
    endfunction

    function void pwm_tick();
      servo_timer = servo_timer + 12'd1;
      servo_pin   = (servo_timer > steer);
      if (servo_timer >= servo_period) servo_timer = '0;
      motor_timer = motor_timer + 12'd1;
      if (motor_timer <= duty) begin
        if (mode == MODE_FWD) bridge |= BRIDGE_FWD_PAIR;
        if (mode == MODE_REV) bridge |= BRIDGE_REV_PAIR;
      end else begin
        if (mode == MODE_FWD) bridge &= ~BRIDGE_FWD_PAIR;
        if (mode == MODE_REV) bridge &= ~BRIDGE_REV_PAIR;
      end
      if (motor_timer >= motor_period) motor_timer = '0;
    endfunction

    function void note_item(logic op, logic [7:0] cmd);
      drive_outputs_t next;
      logic [1:0] code;
      logic follow;
      code   = STATUS_DONE;
      follow = 1'b0;
      if (op == OP_TICK) begin
        pwm_tick();
        code = STATUS_TICK;
        ticks_seen++;
      end else begin
        commands_seen++;
        case (cmd)
          CMD_DUTY_UP_FINE:   raise_duty(DUTY_STEP_FINE);
          CMD_DUTY_UP_COARSE: raise_duty(DUTY_STEP_COARSE);
          CMD_DUTY_DN_FINE:   lower_duty(DUTY_STEP_FINE);
          CMD_DUTY_DN_COARSE: lower_duty(DUTY_STEP_COARSE);
          CMD_FORWARD: begin
            if (mode == MODE_REV) apply_stop();
            bridge &= ~BRIDGE_REV_PAIR;
            lamp   &= ~(LAMP_BRAKE | LAMP_REVERSE);
            mode    = MODE_FWD;
          end
          CMD_REVERSE: begin
            if (mode == MODE_FWD) apply_stop();
            bridge &= ~BRIDGE_FWD_PAIR;
            lamp    = (lamp & ~LAMP_BRAKE) | LAMP_REVERSE;
            mode    = MODE_REV;
          end
          CMD_STOP: apply_stop();
          CMD_STEER_UP: begin
            if (steer < servo_period && steer != 12'hFFF) steer++;
            update_turn_lamps();
          end
          CMD_STEER_DN: begin
            if (steer != 12'd0) steer--;
            update_turn_lamps();
          end
          CMD_STEER_CENTRE: begin
            steer = servo_center;
            update_turn_lamps();
          end
          CMD_REINIT:     clear_car();
          CMD_FOLLOW:     follow = 1'b1;
          CMD_HIGH_BEAM:  accessory ^= ACC_HIGH_BEAM;
          CMD_LOW_BEAM:   accessory ^= ACC_LOW_BEAM;
          CMD_HORN:       accessory ^= ACC_HORN;
          CMD_PERIPHERAL: accessory ^= ACC_PERIPHERAL;
          default: begin
            if (cmd >= CMD_DIGIT_FIRST && cmd <= CMD_DIGIT_LAST) begin
              custom ^= 8'h01 << (cmd - CMD_DIGIT_FIRST);
            end else begin
              code = STATUS_UNKNOWN;
              unknown_seen++;
            end
          end
        endcase
      end
      next.servo_pwm      = servo_pin;
      next.bridge_lines   = bridge;
      next.lamp_bits      = lamp;
      next.accessory_bits = accessory;
      next.custom_bits    = custom;
      next.drive_mode     = mode;
      next.duty_now       = duty;
      next.steer_now      = steer;
      next.status         = code;
      next.follow_request = follow;
      predicted_outputs.push_back(next);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_outputs(drive_outputs_t got);
      drive_outputs_t want;
      results_seen++;
      if (predicted_outputs.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual status %0d duty %0d",
                 $time, got.status, got.duty_now);
        return;
      end
      want = predicted_outputs.pop_front();
      compare_field("servo_pwm", want.servo_pwm, got.servo_pwm);
      compare_field("bridge_lines", want.bridge_lines, got.bridge_lines);
      compare_field("lamp_bits", want.lamp_bits, got.lamp_bits);
      compare_field("accessory_bits", want.accessory_bits, got.accessory_bits);
      compare_field("custom_bits", want.custom_bits, got.custom_bits);
      compare_field("drive_mode", want.drive_mode, got.drive_mode);
      compare_field("duty_now", want.duty_now, got.duty_now);
      compare_field("steer_now", want.steer_now, got.steer_now);
      compare_field("status", want.status, got.status);
      compare_field("follow_request", want.follow_request, got.follow_request);
    endfunction

    function int outstanding();
      return predicted_outputs.size();
    endfunction
  endclass

endpackage

module car_drive_command_pwm_controller_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cdpwm_pkg::*;
  import car_drive_tb_pkg::*;

  // Cycles without a single transfer on either channel before the run is abandoned.
  // The longest quiet stretch of a correct run is the long result hold-off below.
  localparam int STALL_LIMIT   = 2000;
  localparam int LONG_HOLD     = 80;
  // Two register stages between input and result, plus some margin.
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASE_LOOPS   = 150;

  localparam int PRESS_NONE         = 0;
  localparam int PRESS_HOLD_RESULTS = 1;
  localparam int PRESS_DRAIN        = 2;

  // The string-mode opener is not handled by the block and must come back as unknown.
  localparam logic [7:0] CMD_STRING_MODE = 8'h28;

  // Commands that are worth repeating in bursts, so that duty and steering
  // actually run into their limits.
  localparam logic [7:0] REPEATABLE_CMDS [6] = '{
    CMD_DUTY_UP_FINE, CMD_DUTY_UP_COARSE, CMD_DUTY_DN_FINE,
    CMD_DUTY_DN_COARSE, CMD_STEER_UP, CMD_STEER_DN
  };
  localparam logic [7:0] PLAIN_CMDS [9] = '{
    CMD_FORWARD, CMD_REVERSE, CMD_STOP, CMD_STEER_CENTRE, CMD_FOLLOW,
    CMD_HIGH_BEAM, CMD_LOW_BEAM, CMD_HORN, CMD_PERIPHERAL
  };

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [11:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic        in_operation;
  logic [7:0]  in_command;
  logic        out_valid;
  logic        out_ready;
  logic        out_servo_pwm;
  logic [3:0]  out_bridge_lines;
  logic [3:0]  out_lamp_bits;
  logic [3:0]  out_accessory_bits;
  logic [7:0]  out_custom_bits;
  logic [1:0]  out_drive_mode;
  logic [11:0] out_duty_now;
  logic [11:0] out_steer_now;
  logic [1:0]  out_status;
  logic        out_follow_request;

  drive_outputs_t seen_outputs;

  drive_output_checker drive_check = new();

  // Random idling on the sending and receiving side, switched off for the last phase.
  bit tx_gaps;
  bit rx_gaps;
  // A request for a long hold-off of the result channel, in cycles.
  int hold_request = 0;
  int quiet_cycles = 0;
  int settings_used = 0;

  car_drive_command_pwm_controller_top DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_operation       (in_operation),
    .in_command         (in_command),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_servo_pwm      (out_servo_pwm),
    .out_bridge_lines   (out_bridge_lines),
    .out_lamp_bits      (out_lamp_bits),
    .out_accessory_bits (out_accessory_bits),
    .out_custom_bits    (out_custom_bits),
    .out_drive_mode     (out_drive_mode),
    .out_duty_now       (out_duty_now),
    .out_steer_now      (out_steer_now),
    .out_status         (out_status),
    .out_follow_request (out_follow_request)
  );

  always #5 clk = ~clk;

  assign seen_outputs = {out_servo_pwm, out_bridge_lines, out_lamp_bits, out_accessory_bits,
                         out_custom_bits, out_drive_mode, out_duty_now, out_steer_now,
                         out_status, out_follow_request};

  // Both channels are observed at the rising edge. Every accepted input transfer
  // is run through the predictor at once; every accepted result is compared with
  // the oldest prediction still waiting.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready === 1'b1) begin
      drive_check.note_item(in_operation, in_command);
    end
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      drive_check.check_outputs(seen_outputs);
    end
  end

  // Result side. Ready changes only at the falling edge. A long hold-off, when
  // requested, is counted here so that the sender keeps offering items meanwhile
  // and the block has to fill up and refuse further input.
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        out_ready = 1'b0;
        repeat (hold_request) @(negedge clk);
        hold_request = 0;
      end else if (rx_gaps && $urandom_range(0, 7) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk);
      end
      out_ready = 1'b1;
    end
  end

  // Watchdog: any transfer restarts the count.
  initial begin
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("%0t: watchdog expired after %0d cycles without a transfer", $time, STALL_LIMIT);
    $display("status: fail");
    $finish;
  end

  // Offers one item and returns at the falling edge after its transfer. Valid is
  // left high, so a following item is offered back to back unless a gap is drawn.
  task automatic send_item(logic op, logic [7:0] cmd);
    if (tx_gaps && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid     = 1'b1;
    in_operation = op;
    in_command   = cmd;
    do @(posedge clk); while (in_ready !== 1'b1);
    @(negedge clk);
  endtask

  task automatic send_command(logic [7:0] cmd);
    send_item(OP_COMMAND, cmd);
  endtask

  task automatic send_tick();
    // The command byte is ignored on a tick, so it is filled with noise.
    send_item(OP_TICK, 8'($urandom));
  endtask

  // Stops offering items and waits until every predicted result has arrived.
  task automatic drain_results();
    in_valid = 1'b0;
    while (drive_check.outstanding() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] index, logic [11:0] value);
    cfg_we    = 1'b1;
    cfg_index = index;
    cfg_data  = value;
    @(posedge clk);
    drive_check.write_reg(index, value);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Registers are only rewritten once the block is empty and has had time to settle.
  task automatic configure(logic [11:0] motor_period, logic [11:0] servo_period,
                           logic [11:0] servo_center, logic [11:0] initial_duty);
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    write_reg(REG_MOTOR_PERIOD, motor_period);
    write_reg(REG_SERVO_PERIOD, servo_period);
    write_reg(REG_SERVO_CENTER, servo_center);
    write_reg(REG_INITIAL_DUTY, initial_duty);
    settings_used++;
  endtask

  // Random traffic: roughly half ticks, the rest mostly well-formed commands, with
  // bursts of duty and steering steps to reach the saturation points, an occasional
  // reinitialise and some arbitrary bytes.
  task automatic run_random(int loops, int pressure_at, int pressure_kind);
    int pick;
    logic [7:0] cmd;
    for (int k = 0; k < loops; k++) begin
      if (k == pressure_at) begin
        if (pressure_kind == PRESS_HOLD_RESULTS) hold_request = LONG_HOLD;
        else if (pressure_kind == PRESS_DRAIN) drain_results();
      end
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        send_tick();
      end else if (pick < 52) begin
        cmd = REPEATABLE_CMDS[$urandom_range(0, 5)];
        repeat ($urandom_range(3, 12)) send_command(cmd);
      end else if (pick < 68) begin
        send_command(REPEATABLE_CMDS[$urandom_range(0, 5)]);
      end else if (pick < 82) begin
        send_command(PLAIN_CMDS[$urandom_range(0, 8)]);
      end else if (pick < 90) begin
        send_command(CMD_DIGIT_FIRST + 8'($urandom_range(0, 7)));
      end else if (pick < 92) begin
        send_command(CMD_REINIT);
      end else begin
        send_command(8'($urandom));
      end
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = REG_MOTOR_PERIOD;
    cfg_data     = '0;
    in_valid     = 1'b0;
    in_operation = OP_TICK;
    in_command   = '0;
    out_ready    = 1'b0;
    tx_gaps      = 1'b1;
    rx_gaps      = 1'b1;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    settings_used = 1;

    // Directed part at the reset settings: a tick, unknown bytes including the
    // string-mode opener, both direction changes that must pass through stop,
    // every duty, steering, lamp and accessory command, and reinitialise.
    send_tick();
    send_command(CMD_STRING_MODE);
    send_command(8'hFF);
    send_command(CMD_FORWARD);
    send_command(CMD_REVERSE);
    send_tick();
    send_command(CMD_FORWARD);
    send_command(CMD_STOP);
    send_command(CMD_DUTY_UP_FINE);
    send_command(CMD_DUTY_UP_COARSE);
    send_command(CMD_DUTY_DN_FINE);
    send_command(CMD_DUTY_DN_COARSE);
    send_command(CMD_STEER_UP);
    send_command(CMD_STEER_DN);
    send_command(CMD_STEER_CENTRE);
    send_command(CMD_FOLLOW);
    send_command(CMD_HIGH_BEAM);
    send_command(CMD_LOW_BEAM);
    send_command(CMD_HORN);
    send_command(CMD_PERIPHERAL);
    send_command(CMD_DIGIT_FIRST);
    send_command(CMD_DIGIT_LAST);
    send_command(CMD_REINIT);

    // Lowest settings. The duty left over from above now exceeds the motor period,
    // so a raise must be refused; after reinitialise the steering sits at zero, one step
    // below the servo period, and the duty saturates after a single step.
    configure(12'd1, 12'd1, 12'd0, 12'd0);
    send_command(CMD_DUTY_UP_FINE);
    send_command(CMD_REINIT);
    send_command(CMD_STEER_DN);
    send_command(CMD_DUTY_DN_FINE);
    send_command(CMD_STEER_UP);
    send_command(CMD_STEER_UP);
    send_command(CMD_DUTY_UP_FINE);
    send_command(CMD_DUTY_UP_FINE);

    // Short periods so that both PWM timers wrap many times. Part-way through, the
    // result side holds off for a long stretch while items keep being offered.
    configure(12'd12, 12'd20, 12'd6, 12'd5);
    run_random(PHASE_LOOPS, 60, PRESS_HOLD_RESULTS);

    // Highest settings; the sender also pauses once until everything has come back.
    configure(12'd4095, 12'd4095, 12'd4095, 12'd4095);
    run_random(PHASE_LOOPS, 60, PRESS_DRAIN);

    configure(12'd1, 12'd1, 12'd0, 12'd0);
    run_random(PHASE_LOOPS, -1, PRESS_NONE);

    // Initial duty above the motor period: every reinitialise lands out of range.
    configure(12'd8, 12'd10, 12'd9, 12'd15);
    run_random(PHASE_LOOPS, -1, PRESS_NONE);

    // Final phase with both sides running flat out.
    configure(12'd25, 12'd40, 12'd20, 12'd12);
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    run_random(PHASE_LOOPS, -1, PRESS_NONE);

    drain_results();
    repeat (10) @(negedge clk);

    if (drive_check.outstanding() != 0) begin
      $display("%0t: %0d predicted results never arrived", $time, drive_check.outstanding());
    end
    $display("Covered %0d ticks and %0d command bytes (%0d unknown), %0d results compared,",
             drive_check.ticks_seen, drive_check.commands_seen, drive_check.unknown_seen,
             drive_check.results_seen);
    $display("across %0d register settings with a long result stall and a full drain.",
             settings_used);
    if (drive_check.mismatches == 0 && drive_check.outstanding() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
